### hw/rtl/rsnh_pkg.sv
// ----------------------------------------------------------------------------
// rsnh_pkg
// Shared types and constants of the ray segment nearest hit block.
// ----------------------------------------------------------------------------
package rsnh_pkg;

  localparam int COORD_W   = 16;
  localparam int POINT_W   = 18;
  localparam int LEN_W     = 15;
  localparam int DIST_W    = 40;
  localparam int DIR_FRAC  = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int MUL_W     = 20;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int CROSS_W   = 38;
  localparam int ACC_W     = 56;
  localparam int QUO_W     = 17;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN  = 3'd4;

  localparam logic signed [COORD_W-1:0] DIR_X_RST   = 16'sd16384;
  localparam logic [LEN_W-1:0]          MAX_LEN_RST = 15'd16000;
  localparam logic signed [POINT_W-1:0] FAR_X_RST   = 18'sd16000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic                      first;
    logic                      last;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic [LEN_W-1:0]          max_len;
  } cfg_t;

endpackage

### hw/rtl/rsnh_front.sv
// ----------------------------------------------------------------------------
// rsnh_front
// Input stage: accept a segment word, unpack its fields, hand it to the queue.
// ----------------------------------------------------------------------------
module rsnh_front import rsnh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  logic  hold_r;
  logic  hold_nxt;
  item_t item_r;

  assign q_push    = hold_r && !q_full;
  assign in_tready = !hold_r || !q_full;
  assign q_item    = item_r;

  always_comb begin
    hold_nxt = hold_r;
    if (q_push) begin
      hold_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      hold_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
    if (in_tvalid && in_tready) begin
      item_r.x1    <= in_tdata[15:0];
      item_r.y1    <= in_tdata[31:16];
      item_r.x2    <= in_tdata[47:32];
      item_r.y2    <= in_tdata[63:48];
      item_r.first <= in_tuser;
      item_r.last  <= in_tlast;
    end
  end

endmodule

### hw/rtl/rsnh_queue.sv
// ----------------------------------------------------------------------------
// rsnh_queue
// Two-entry queue of segment items between the front and the back.
// ----------------------------------------------------------------------------
module rsnh_queue import rsnh_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t pop_item
);

  item_t       mem_r [2];
  logic        wp_r;
  logic        rp_r;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_item = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

### hw/rtl/rsnh_back.sv
// ----------------------------------------------------------------------------
// rsnh_back
// Intersection sequencer: one shared multiplier, a restoring divider and the
// nearest-hit state, with a registered result word.
// ----------------------------------------------------------------------------
module rsnh_back import rsnh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_empty,
  output logic        q_pop,
  input  item_t       q_item,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_FX   = 5'd1;
  localparam logic [4:0] ST_FY   = 5'd2;
  localparam logic [4:0] ST_FL   = 5'd3;
  localparam logic [4:0] ST_D0   = 5'd4;
  localparam logic [4:0] ST_D1   = 5'd5;
  localparam logic [4:0] ST_T0   = 5'd6;
  localparam logic [4:0] ST_T1   = 5'd7;
  localparam logic [4:0] ST_U0   = 5'd8;
  localparam logic [4:0] ST_U1   = 5'd9;
  localparam logic [4:0] ST_CHK  = 5'd10;
  localparam logic [4:0] ST_ML   = 5'd11;
  localparam logic [4:0] ST_MH   = 5'd12;
  localparam logic [4:0] ST_DV   = 5'd13;
  localparam logic [4:0] ST_PT   = 5'd14;
  localparam logic [4:0] ST_SX   = 5'd15;
  localparam logic [4:0] ST_SY   = 5'd16;
  localparam logic [4:0] ST_OUT  = 5'd17;

  logic [4:0]                  st_r;
  item_t                       it_r;
  logic signed [POINT_W-1:0]   far_x_r, far_y_r;
  logic signed [POINT_W-1:0]   near_x_r, near_y_r;
  logic [DIST_W-1:0]           dist_r;
  logic                        any_r;
  logic signed [CROSS_W-1:0]   t0_r, den_r, nt_r, nu_r;
  logic                        sel_r;
  logic                        neg_r;
  logic [15:0]                 dmag_r;
  logic [ACC_W-1:0]            acc_r;
  logic [QUO_W-1:0]            quo_r;
  logic [4:0]                  cnt_r;
  logic signed [POINT_W-1:0]   ix_r, iy_r;
  logic [DIST_W-1:0]           sq_r;
  logic                        ov_r;
  logic signed [POINT_W-1:0]   ox_r, oy_r;
  logic                        oh_r, ol_r;

  logic signed [MUL_W-1:0]     mul_a, mul_b;
  logic signed [PROD_W-1:0]    mul_p;
  logic signed [MUL_W-1:0]     x1, y1, x2, y2, x3, y3, x4, y4;
  logic signed [PROD_W-1:0]    rnd;
  logic signed [POINT_W-1:0]   far_calc;
  logic signed [CROSS_W-1:0]   den_a, nt_a, nu_a;
  logic                        is_hit;
  logic signed [MUL_W-1:0]     diff;
  logic [15:0]                 dmag;
  logic [ACC_W-1:0]            den_sh;
  logic signed [POINT_W-1:0]   pt;
  logic [DIST_W-1:0]           d2;
  logic                        slot_free;

  assign x1 = MUL_W'(it_r.x1);
  assign y1 = MUL_W'(it_r.y1);
  assign x2 = MUL_W'(it_r.x2);
  assign y2 = MUL_W'(it_r.y2);
  assign x3 = MUL_W'(cfg.origin_x);
  assign y3 = MUL_W'(cfg.origin_y);
  assign x4 = MUL_W'(far_x_r);
  assign y4 = MUL_W'(far_y_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      ST_FX:  begin mul_a = MUL_W'(signed'({1'b0, cfg.max_len})); mul_b = MUL_W'(cfg.dir_x); end
      ST_FY:  begin mul_a = MUL_W'(signed'({1'b0, cfg.max_len})); mul_b = MUL_W'(cfg.dir_y); end
      ST_FL:  begin
        mul_a = MUL_W'(signed'({1'b0, cfg.max_len}));
        mul_b = MUL_W'(signed'({1'b0, cfg.max_len}));
      end
      ST_D0:  begin mul_a = x1 - x2; mul_b = y3 - y4; end
      ST_D1:  begin mul_a = y1 - y2; mul_b = x3 - x4; end
      ST_T0:  begin mul_a = x1 - x3; mul_b = y3 - y4; end
      ST_T1:  begin mul_a = y1 - y3; mul_b = x3 - x4; end
      ST_U0:  begin mul_a = x1 - x3; mul_b = y1 - y2; end
      ST_U1:  begin mul_a = y1 - y3; mul_b = x1 - x2; end
      ST_ML:  begin
        mul_a = MUL_W'(signed'({1'b0, nt_r[18:0]}));
        mul_b = MUL_W'(signed'({1'b0, dmag}));
      end
      ST_MH:  begin
        mul_a = MUL_W'(signed'({1'b0, nt_r[37:19]}));
        mul_b = MUL_W'(signed'({1'b0, dmag_r}));
      end
      ST_SX:  begin mul_a = x3 - MUL_W'(ix_r); mul_b = x3 - MUL_W'(ix_r); end
      ST_SY:  begin mul_a = y3 - MUL_W'(iy_r); mul_b = y3 - MUL_W'(iy_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    rnd      = (mul_p + PROD_W'(1 << (DIR_FRAC - 1))) >>> DIR_FRAC;
    far_calc = POINT_W'(st_r == ST_FX ? MUL_W'(cfg.origin_x) : MUL_W'(cfg.origin_y))
             + rnd[POINT_W-1:0];
    den_a    = den_r[CROSS_W-1] ? -den_r : den_r;
    nt_a     = den_r[CROSS_W-1] ? -nt_r  : nt_r;
    nu_a     = den_r[CROSS_W-1] ? -nu_r  : nu_r;
    is_hit   = (den_a != '0) && !nt_a[CROSS_W-1] && (nt_a <= den_a)
             && !nu_a[CROSS_W-1] && (nu_a <= den_a);
    diff     = sel_r ? (y2 - y1) : (x2 - x1);
    dmag     = diff[MUL_W-1] ? 16'(-diff) : 16'(diff);
    den_sh   = ACC_W'(den_r) << cnt_r;
    pt       = POINT_W'(sel_r ? y1 : x1)
             + (neg_r ? -POINT_W'(quo_r) : POINT_W'(quo_r));
    d2       = sq_r + DIST_W'(mul_p);
    slot_free = !ov_r || out_tready;
  end

  assign q_pop      = (st_r == ST_IDLE) && !q_empty;
  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, oy_r, ox_r};
  assign out_tuser  = oh_r;
  assign out_tlast  = ol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      ov_r     <= 1'b0;
      far_x_r  <= FAR_X_RST;
      far_y_r  <= '0;
      near_x_r <= '0;
      near_y_r <= '0;
      dist_r   <= '0;
      any_r    <= 1'b0;
    end else begin
      if ((st_r == ST_OUT) && slot_free) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (!q_empty) begin
            it_r <= q_item;
            st_r <= q_item.first ? ST_FX : ST_D0;
          end
        end
        ST_FX: begin far_x_r <= far_calc; st_r <= ST_FY; end
        ST_FY: begin far_y_r <= far_calc; st_r <= ST_FL; end
        ST_FL: begin
          near_x_r <= far_x_r;
          near_y_r <= far_y_r;
          dist_r   <= DIST_W'(mul_p);
          any_r    <= 1'b0;
          st_r     <= ST_D0;
        end
        ST_D0: begin t0_r <= CROSS_W'(mul_p); st_r <= ST_D1; end
        ST_D1: begin den_r <= t0_r - CROSS_W'(mul_p); st_r <= ST_T0; end
        ST_T0: begin t0_r <= CROSS_W'(mul_p); st_r <= ST_T1; end
        ST_T1: begin nt_r <= t0_r - CROSS_W'(mul_p); st_r <= ST_U0; end
        ST_U0: begin t0_r <= CROSS_W'(mul_p); st_r <= ST_U1; end
        ST_U1: begin nu_r <= t0_r - CROSS_W'(mul_p); st_r <= ST_CHK; end
        ST_CHK: begin
          den_r <= den_a;
          nt_r  <= nt_a;
          sel_r <= 1'b0;
          st_r  <= is_hit ? ST_ML : ST_OUT;
        end
        ST_ML: begin
          neg_r  <= diff[MUL_W-1];
          dmag_r <= dmag;
          acc_r  <= ACC_W'(mul_p);
          st_r   <= ST_MH;
        end
        ST_MH: begin
          acc_r <= acc_r + (ACC_W'(mul_p) << 19);
          st_r  <= ST_DV;
          cnt_r <= 5'(QUO_W);
        end
        ST_DV: begin
          if (cnt_r == 5'(QUO_W)) begin
            acc_r <= acc_r + ACC_W'(den_r >>> 1);
            quo_r <= '0;
            cnt_r <= 5'(QUO_W - 1);
          end else begin
            if (acc_r >= den_sh) begin
              acc_r        <= acc_r - den_sh;
              quo_r[cnt_r] <= 1'b1;
            end
            if (cnt_r == 5'd0) begin
              st_r <= ST_PT;
            end else begin
              cnt_r <= cnt_r - 5'd1;
            end
          end
        end
        ST_PT: begin
          if (!sel_r) begin
            ix_r  <= pt;
            sel_r <= 1'b1;
            st_r  <= ST_ML;
          end else begin
            iy_r <= pt;
            st_r <= ST_SX;
          end
        end
        ST_SX: begin sq_r <= DIST_W'(mul_p); st_r <= ST_SY; end
        ST_SY: begin
          any_r <= 1'b1;
          if (d2 < dist_r) begin
            dist_r   <= d2;
            near_x_r <= ix_r;
            near_y_r <= iy_r;
          end
          st_r <= ST_OUT;
        end
        ST_OUT: begin
          if (slot_free) begin
            ox_r <= near_x_r;
            oy_r <= near_y_r;
            oh_r <= any_r;
            ol_r <= it_r.last;
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == ST_IDLE) && !q_empty)
    else $error("pop outside idle");

  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DV) |-> (den_r > 0))
    else $error("divide by non-positive denominator");

  a_upd_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SY) |=> (st_r == ST_OUT))
    else $error("update not followed by output");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT) && ov_r && !out_tready |=> ov_r && (st_r == ST_OUT))
    else $error("result overwritten while stalled");

endmodule

### hw/rtl/ray_segment_nearest_hit.sv
// ----------------------------------------------------------------------------
// ray_segment_nearest_hit
// Nearest hit of one ray against a stream of wall segments.
// ----------------------------------------------------------------------------
// Write origin, direction and max length on the cfg channel (index 0..4) while
// the block is idle. Stream segments on in_*: tdata holds start x/y, end x/y,
// tuser marks the first segment of a ray, tlast the last. Each segment yields
// one word on out_*: tdata holds end x/y, tuser the hit flag, tlast the last
// mark copied from the input.
// The sequencer runs each segment from its idle step through its output
// step; a segment that starts a ray first passes the far-end steps FX, FY
// and FL. The result word is valid on the next cycle after the output step.
// One segment is processed at a time, and a new one is taken only in the
// idle step. Every product comes from the shared multiplier; a hit runs the
// 17-step restoring divider once per coordinate. A two-word queue and an
// input register let the source run ahead by three words.
// Reset clears the queue, the result valid flag and the ray state; the far
// end resets to the default ray end. A pending result holds while out_tready
// is low, and the sequencer waits in its output step; input fills the queue.
// ----------------------------------------------------------------------------
module ray_segment_nearest_hit import rsnh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // seg_start_x, seg_start_y, seg_end_x, seg_end_y
  input  logic                 in_tuser,   // first_segment
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata,  // end_x, end_y, zero fill
  output logic                 out_tuser,  // hit
  output logic                 out_tlast
);

  cfg_t  cfg_r;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  item_t f_item;
  item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x <= '0;
      cfg_r.origin_y <= '0;
      cfg_r.dir_x    <= DIR_X_RST;
      cfg_r.dir_y    <= '0;
      cfg_r.max_len  <= MAX_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_ORIGIN_X: cfg_r.origin_x <= cfg_data;
        REG_ORIGIN_Y: cfg_r.origin_y <= cfg_data;
        REG_DIR_X:    cfg_r.dir_x    <= cfg_data;
        REG_DIR_Y:    cfg_r.dir_y    <= cfg_data;
        REG_MAX_LEN:  cfg_r.max_len  <= cfg_data[LEN_W-1:0];
        default:      cfg_r          <= cfg_r;
      endcase
    end
  end

  rsnh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (f_item)
  );

  rsnh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_item  (q_item)
  );

  rsnh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
